// ===== rtl/fls_pkg.sv =====
// ----------------------------------------------------------------------------
// fls_pkg
// Shared types and constants for the free-list slot allocator.
// ----------------------------------------------------------------------------
package fls_pkg;

   // width of the slot fields on both channels
   localparam int SLOT_W = 6;

   // request codes
   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   // request transaction payload
   typedef struct packed {
      opcode_type          opcode;
      logic [SLOT_W-1:0]   slot_index;
   } req_type;

   // response transaction payload
   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic                granted;
   } rsp_type;

endpackage

// ===== rtl/free_list_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// free_list_slot_allocator_unit
// LIFO free-list allocator over a fixed pool of slots: allocate pops the
// head slot, free pushes the given slot onto the head.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  fls_pkg::req_type
//   rsp_     out        rsp_valid / rsp_ready  fls_pkg::rsp_type
//
// One transaction per cycle while req_ready is high; each response appears in
// the cycle after its request is accepted, from the response register.
// After reset the link memory is swept with req_ready low.
// The link of the head slot is held in a register and refilled from the
// memory read port, so back-to-back allocates do not stall.
// req_ready drops while the link memory is swept or the response register is full and not taken.
// ----------------------------------------------------------------------------
module free_list_slot_allocator_unit #(
   parameter int SLOTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fls_pkg::rsp_type rsp_data
);

   import fls_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS+1);
   localparam int CW = (LW > SLOT_W) ? LW : SLOT_W;
   localparam logic [LW-1:0] END_MARK = LW'(SLOTS);
   localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] hlink_ff, hlink_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [LW-1:0] hlink_eff;
   logic [LW-1:0] rd_data;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic [LW-1:0] wr_data;
   logic          wr_en;
   logic          link_busy;
   logic          accept;
   logic          is_free;
   logic          head_empty;
   logic          free_ok;
   logic          pop_grant;
   logic          push_ok;

   fls_link_store #(
      .SLOTS (SLOTS)
   ) u_link_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (link_busy)
   );

   // handshake
   assign req_ready = !link_busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // request decode
   always_comb begin
      hlink_eff  = pend_ff ? rd_data : hlink_ff;
      is_free    = (req_data.opcode == OP_FREE);
      head_empty = (head_ff == END_MARK);
      free_ok    = (CW'(req_data.slot_index) < SLOTS_C);
      pop_grant  = accept && !is_free && !head_empty;
      push_ok    = accept && is_free && free_ok;
   end

   // head, head link and memory ports
   always_comb begin
      head_in  = head_ff;
      hlink_in = hlink_eff;
      pend_in  = 1'b0;
      if (pop_grant) begin
         head_in = hlink_eff;
         pend_in = 1'b1;
      end else if (push_ok) begin
         head_in  = LW'(req_data.slot_index);
         hlink_in = head_ff;
      end
      wr_en   = push_ok;
      wr_addr = IW'(req_data.slot_index);
      wr_data = head_ff;
      rd_addr = IW'(hlink_eff);
   end

   // response build
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         if (is_free) begin
            rsp_data_in.slot    = req_data.slot_index;
            rsp_data_in.granted = free_ok;
         end else if (head_empty) begin
            rsp_data_in.slot    = '0;
            rsp_data_in.granted = 1'b0;
         end else begin
            rsp_data_in.slot    = SLOT_W'(head_ff);
            rsp_data_in.granted = 1'b1;
         end
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         hlink_ff     <= LW'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         hlink_ff     <= hlink_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // no request taken while the link memory is being initialized
   assert property (@(posedge clock) disable iff (reset)
      link_busy |-> !accept)
      else $error("request accepted during link init");

   // a pending link read only follows a granted allocate
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(pop_grant))
      else $error("link read pending without a pop");

   // head is a slot or the end marker
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= END_MARK)
      else $error("head out of range");
`endif

endmodule

// ===== rtl/fls_link_store.sv =====
// ----------------------------------------------------------------------------
// fls_link_store
// Next-link memory of the free list, one entry per slot, with a registered
// read port and a write port. After reset a sweep writes entry i with i+1,
// one entry per cycle, while busy is high.
// ----------------------------------------------------------------------------
module fls_link_store #(
   parameter int SLOTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(SLOTS)-1:0]     wr_addr,
   input  logic [$clog2(SLOTS+1)-1:0]   wr_data,
   input  logic [$clog2(SLOTS)-1:0]     rd_addr,
   output logic [$clog2(SLOTS+1)-1:0]   rd_data,
   output logic                         busy
);

   localparam int IW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS+1);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   logic [LW-1:0] mem [SLOTS];
   logic [LW-1:0] rd_data_ff;
   logic [IW-1:0] clr_ff;
   logic [IW-1:0] clr_in;
   logic          busy_ff;
   logic          busy_in;

   // init sweep counter
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + IW'(1);
         if (clr_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= LW'(clr_ff) + LW'(1);
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free-list slot allocator. A local LIFO pool
// predicts every response from the accepted requests; the checker matches
// each response against the oldest prediction while both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
   import fls_pkg::*;

   localparam int POOL_SLOTS = 64;
   localparam logic [6:0] POOL_END = 7'(POOL_SLOTS);
   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // local copy of the free list
   logic [6:0] pool_head;
   logic [6:0] pool_link [POOL_SLOTS];

   rsp_type    pending_grants [$];
   logic [5:0] held_slots [$];
   int         mismatches = 0;
   int         cycles = 0;
   int         req_idle_pct = 0;
   int         rsp_stall_pct = 0;

   free_list_slot_allocator_unit #(.SLOTS(POOL_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // pool state after reset: chain 0, 1, 2, ... then the end marker
   initial begin
      pool_head = '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         pool_link[i] = 7'(i + 1);
      end
   end

   // work out the response of one accepted request and track held slots
   task automatic predict_grant(input req_type r);
      rsp_type want;
      logic [6:0] top;
      top = pool_head;
      if (r.opcode == OP_ALLOC) begin
         if (top >= POOL_END) begin
            want.slot    = '0;
            want.granted = 1'b0;
         end else begin
            pool_head    = pool_link[top[5:0]];
            want.slot    = top[5:0];
            want.granted = 1'b1;
            held_slots   = {held_slots, top[5:0]};
         end
      end else if (int'(r.slot_index) >= POOL_SLOTS) begin
         want.slot    = r.slot_index;
         want.granted = 1'b0;
      end else begin
         pool_link[r.slot_index] = pool_head;
         pool_head    = {1'b0, r.slot_index};
         want.slot    = r.slot_index;
         want.granted = 1'b1;
         foreach (held_slots[k]) begin
            if (held_slots[k] == r.slot_index) begin
               held_slots.delete(k);
               break;
            end
         end
      end
      pending_grants = {pending_grants, want};
   endtask

   // present one request, hold it until taken, then maybe go idle
   task automatic send_req(input opcode_type op, input logic [SLOT_W-1:0] idx);
      req_type r;
      r.opcode     = op;
      r.slot_index = idx;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_grant(r);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < req_idle_pct) @(posedge clock);
      end
   endtask

   // hold off the sender until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   // free a random held slot
   task automatic free_held();
      int k;
      k = $urandom_range(0, held_slots.size() - 1);
      send_req(OP_FREE, held_slots[k]);
   endtask

   // lifo order on a short sequence
   task automatic test_directed();
      send_req(OP_ALLOC, 6'h3f);
      send_req(OP_ALLOC, '0);
      send_req(OP_ALLOC, '0);
      send_req(OP_FREE, 6'd1);
      send_req(OP_ALLOC, '0);
      send_req(OP_FREE, 6'd0);
      send_req(OP_FREE, 6'd2);
      send_req(OP_ALLOC, '0);
      send_req(OP_ALLOC, '0);
      send_req(OP_FREE, 6'd1);
      send_req(OP_FREE, 6'd2);
      send_req(OP_FREE, 6'd0);
   endtask

   // drain the pool, allocate past the end, then return everything
   task automatic test_exhaust();
      while (pool_head != POOL_END) send_req(OP_ALLOC, 6'($urandom));
      repeat (3) send_req(OP_ALLOC, 6'($urandom));
      wait_drained();
      while (held_slots.size() != 0) free_held();
   endtask

   // well-formed traffic: frees only return held slots, alloc bias drifts
   task automatic test_random_walk(input int count, input int idle, input int stall);
      int alloc_pct;
      req_idle_pct  = idle;
      rsp_stall_pct = stall;
      alloc_pct     = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) alloc_pct = 25 * $urandom_range(1, 3);
         if (held_slots.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
            send_req(OP_ALLOC, 6'($urandom));
         end else begin
            free_held();
         end
      end
   endtask

   // noise last: random frees include double frees that loop the list
   task automatic test_double_free(input int count);
      req_idle_pct  = 11;
      rsp_stall_pct = 11;
      for (int n = 0; n < count; n++) begin
         send_req(opcode_type'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected transaction slot=%0d granted=%0b",
                     $time, rsp_data.slot, rsp_data.granted);
            mismatches++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_data.slot !== want.slot) begin
               $display("%0t: slot expected %0d actual %0d",
                        $time, want.slot, rsp_data.slot);
               mismatches++;
            end
            if (rsp_data.granted !== want.granted) begin
               $display("%0t: granted expected %0b actual %0b",
                        $time, want.granted, rsp_data.granted);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_exhaust();
      test_random_walk(260, 0, 0);
      test_random_walk(260, 69, 0);
      test_random_walk(260, 0, 69);
      test_random_walk(260, 11, 11);
      wait_drained();
      test_double_free(150);
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
